// ===== design/ftp_passive_reply_parser_defines.svh =====
// ----------------------------------------------------------------------------
// FTP passive reply parser assertion macros
// Shared property templates for the checker of the passive reply parser.
// ----------------------------------------------------------------------------
`ifndef FTP_PASSIVE_REPLY_PARSER_DEFINES_SVH
`define FTP_PASSIVE_REPLY_PARSER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define FPR_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define FPR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/fpr_pkg.sv =====
// ----------------------------------------------------------------------------
// FTP passive reply parser package
// Phase encoding, character codes, beat and result types, and the
// decimal accumulate helpers.
// ----------------------------------------------------------------------------
package fpr_pkg;

   typedef enum logic [2:0] {
      PHASE_CODE = 3'd0,
      PHASE_SEEK = 3'd1,
      PHASE_HOST = 3'd2,
      PHASE_PORT = 3'd3,
      PHASE_EOL  = 3'd4
   } phase_type;

   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_LPAREN  = 8'h28;
   localparam logic [7:0] CHAR_RPAREN  = 8'h29;
   localparam logic [7:0] CHAR_COMMA   = 8'h2C;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;

   localparam logic [2:0] HOST_COMMAS     = 3'd4;
   localparam logic [1:0] CODE_DIGITS_MAX = 2'd3;
   localparam logic [7:0] PART_MAX        = 8'd255;
   localparam logic [9:0] CODE_MAX        = 10'd999;

   typedef struct packed {
      logic       valid;
      logic [7:0] data;
   } beat_type;

   typedef struct packed {
      logic [9:0]  reply_code;
      logic [15:0] data_port;
      logic        port_overflow;
   } result_type;

   typedef struct packed {
      logic [7:0] value;
      logic       overflow;
   } part_type;

   function automatic logic is_digit(input logic [7:0] b);
      return (b >= CHAR_ZERO) && (b <= CHAR_NINE);
   endfunction

   // Adds one decimal digit to a port part, holding it at the part maximum.
   function automatic part_type accumulate_part(input logic [7:0] part,
                                                input logic [3:0] digit);
      logic [11:0] sum;
      part_type    r;
      sum = {4'd0, part} * 12'd10 + {8'd0, digit};
      if (sum > {4'd0, PART_MAX}) begin
         r.value    = PART_MAX;
         r.overflow = 1'b1;
      end else begin
         r.value    = sum[7:0];
         r.overflow = 1'b0;
      end
      return r;
   endfunction

   function automatic logic [9:0] accumulate_code(input logic [9:0] code,
                                                  input logic [3:0] digit);
      logic [13:0] sum;
      sum = {4'd0, code} * 14'd10 + {10'd0, digit};
      return sum[9:0];
   endfunction

endpackage

// ===== design/fpr_channels.sv =====
// ----------------------------------------------------------------------------
// FTP passive reply parser channels
// Valid/ready interfaces for the byte input and the result output.
// ----------------------------------------------------------------------------
interface fpr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_in;

   modport source (output valid, output byte_in, input ready);
   modport sink (input valid, input byte_in, output ready);
endinterface

interface fpr_rsp_if;
   logic        valid;
   logic        ready;
   logic [9:0]  reply_code;
   logic [15:0] data_port;
   logic        port_overflow;

   modport source (output valid, output reply_code, output data_port,
                   output port_overflow, input ready);
   modport sink (input valid, input reply_code, input data_port,
                 input port_overflow, output ready);
endinterface

// ===== design/fpr_in_stage.sv =====
// ----------------------------------------------------------------------------
// FTP passive reply parser input stage
// Holds one received byte until the parser consumes it.
// ----------------------------------------------------------------------------
module fpr_in_stage (
   input  logic             clock,
   input  logic             reset,
   fpr_req_if.sink          req,
   input  logic             advance,
   output fpr_pkg::beat_type beat
);

   logic       valid_ff;
   logic       valid_in;
   logic [7:0] data_ff;
   logic       accept;

   assign req.ready = !reset && (!valid_ff || advance);
   assign accept    = req.valid && req.ready;

   always_comb begin
      if (accept) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         data_ff <= req.byte_in;
      end
   end

   assign beat.valid = valid_ff;
   assign beat.data  = data_ff;

endmodule

// ===== design/fpr_parser.sv =====
// ----------------------------------------------------------------------------
// FTP passive reply parser phase machine
// Walks the reply line one byte per beat and forms the result on newline.
// ----------------------------------------------------------------------------
module fpr_parser (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic [7:0]         data,
   output logic               emit,
   output fpr_pkg::result_type result
);

   fpr_pkg::phase_type phase_ff, phase_in;
   logic [2:0]         comma_count_ff, comma_count_in;
   logic [9:0]         code_value_ff, code_value_in;
   logic [1:0]         code_digits_ff, code_digits_in;
   logic [7:0]         high_part_ff, high_part_in;
   logic [7:0]         low_part_ff, low_part_in;
   logic               in_low_part_ff, in_low_part_in;
   logic               overflow_ff, overflow_in;
   logic [7:0]         digit_full;
   logic [3:0]         digit;
   logic [2:0]         comma_next;
   fpr_pkg::part_type  high_acc;
   fpr_pkg::part_type  low_acc;

   assign digit_full = data - fpr_pkg::CHAR_ZERO;
   assign digit      = digit_full[3:0];
   assign comma_next = comma_count_ff + 3'd1;
   assign high_acc   = fpr_pkg::accumulate_part(high_part_ff, digit);
   assign low_acc    = fpr_pkg::accumulate_part(low_part_ff, digit);

   assign result.reply_code    = code_value_ff;
   assign result.data_port     = {high_part_ff, low_part_ff};
   assign result.port_overflow = overflow_ff;

   always_comb begin
      phase_in       = phase_ff;
      comma_count_in = comma_count_ff;
      code_value_in  = code_value_ff;
      code_digits_in = code_digits_ff;
      high_part_in   = high_part_ff;
      low_part_in    = low_part_ff;
      in_low_part_in = in_low_part_ff;
      overflow_in    = overflow_ff;
      emit           = 1'b0;
      if (advance) begin
         unique case (phase_ff)
            fpr_pkg::PHASE_CODE: begin
               if (data == fpr_pkg::CHAR_SPACE) begin
                  phase_in = fpr_pkg::PHASE_SEEK;
               end else if (fpr_pkg::is_digit(data) &&
                            (code_digits_ff < fpr_pkg::CODE_DIGITS_MAX)) begin
                  code_value_in  = fpr_pkg::accumulate_code(code_value_ff, digit);
                  code_digits_in = code_digits_ff + 2'd1;
               end
            end
            fpr_pkg::PHASE_SEEK: begin
               if (data == fpr_pkg::CHAR_LPAREN) begin
                  phase_in = fpr_pkg::PHASE_HOST;
               end
            end
            fpr_pkg::PHASE_HOST: begin
               if (data == fpr_pkg::CHAR_COMMA) begin
                  comma_count_in = comma_next;
                  if (comma_next == fpr_pkg::HOST_COMMAS) begin
                     phase_in       = fpr_pkg::PHASE_PORT;
                     high_part_in   = 8'd0;
                     low_part_in    = 8'd0;
                     in_low_part_in = 1'b0;
                  end
               end
            end
            fpr_pkg::PHASE_PORT: begin
               if (data == fpr_pkg::CHAR_RPAREN) begin
                  phase_in = fpr_pkg::PHASE_EOL;
               end else if (data == fpr_pkg::CHAR_COMMA) begin
                  in_low_part_in = 1'b1;
               end else if (fpr_pkg::is_digit(data)) begin
                  if (in_low_part_ff) begin
                     low_part_in = low_acc.value;
                     overflow_in = overflow_ff | low_acc.overflow;
                  end else begin
                     high_part_in = high_acc.value;
                     overflow_in  = overflow_ff | high_acc.overflow;
                  end
               end
            end
            fpr_pkg::PHASE_EOL: begin
               if (data == fpr_pkg::CHAR_NEWLINE) begin
                  emit           = 1'b1;
                  phase_in       = fpr_pkg::PHASE_CODE;
                  comma_count_in = 3'd0;
                  code_value_in  = 10'd0;
                  code_digits_in = 2'd0;
                  high_part_in   = 8'd0;
                  low_part_in    = 8'd0;
                  in_low_part_in = 1'b0;
                  overflow_in    = 1'b0;
               end
            end
            default: begin
               phase_in       = fpr_pkg::PHASE_CODE;
               comma_count_in = 3'd0;
               code_value_in  = 10'd0;
               code_digits_in = 2'd0;
               high_part_in   = 8'd0;
               low_part_in    = 8'd0;
               in_low_part_in = 1'b0;
               overflow_in    = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= fpr_pkg::PHASE_CODE;
         comma_count_ff <= 3'd0;
         code_value_ff  <= 10'd0;
         code_digits_ff <= 2'd0;
         high_part_ff   <= 8'd0;
         low_part_ff    <= 8'd0;
         in_low_part_ff <= 1'b0;
         overflow_ff    <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         comma_count_ff <= comma_count_in;
         code_value_ff  <= code_value_in;
         code_digits_ff <= code_digits_in;
         high_part_ff   <= high_part_in;
         low_part_ff    <= low_part_in;
         in_low_part_ff <= in_low_part_in;
         overflow_ff    <= overflow_in;
      end
   end

endmodule

// ===== design/fpr_out_stage.sv =====
// ----------------------------------------------------------------------------
// FTP passive reply parser result stage
// Holds one finished result until the downstream side takes the beat.
// ----------------------------------------------------------------------------
module fpr_out_stage (
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  fpr_pkg::result_type result,
   output logic               slot_free,
   fpr_rsp_if.source          rsp
);

   logic                valid_ff;
   logic                valid_in;
   fpr_pkg::result_type result_ff;

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp.ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result;
      end
   end

   assign slot_free         = !valid_ff || rsp.ready;
   assign rsp.valid         = valid_ff && !reset;
   assign rsp.reply_code    = result_ff.reply_code;
   assign rsp.data_port     = result_ff.data_port;
   assign rsp.port_overflow = result_ff.port_overflow;

endmodule

// ===== design/ftp_passive_reply_parser.sv =====
// ----------------------------------------------------------------------------
// FTP passive reply parser
// A newline byte is registered in the input stage, then its result in the result stage.
// Throughput: one byte per cycle, unless a waiting result is held by the downstream side.
// Input and result registers let a byte enter while a result waits.
// Reset is synchronous and returns the parser to reading the reply code.
// ----------------------------------------------------------------------------
module ftp_passive_reply_parser (
   input  logic      clock,
   input  logic      reset,
   fpr_req_if.sink   req_bus,
   fpr_rsp_if.source rsp_bus
);

   fpr_pkg::beat_type   beat;
   fpr_pkg::result_type result;
   logic                advance;
   logic                emit;
   logic                slot_free;

   assign advance = beat.valid && slot_free;

   fpr_in_stage u_in_stage (
      .clock   (clock),
      .reset   (reset),
      .req     (req_bus),
      .advance (advance),
      .beat    (beat)
   );

   fpr_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .data    (beat.data),
      .emit    (emit),
      .result  (result)
   );

   fpr_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .load      (emit),
      .result    (result),
      .slot_free (slot_free),
      .rsp       (rsp_bus)
   );

endmodule

// ===== design/fpr_checker.sv =====
// ----------------------------------------------------------------------------
// FTP passive reply parser checker
// Port-level properties of the parser, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "ftp_passive_reply_parser_defines.svh"

module fpr_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [7:0]  req_byte_in,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [9:0]  rsp_reply_code,
   input logic [15:0] rsp_data_port,
   input logic        rsp_port_overflow
);

   `FPR_ASSERT_SAME(a_idle_after_reset, clock, reset, $past(reset), !rsp_valid, "result after reset")
   `FPR_ASSERT_SAME(a_result_from_newline, clock, reset, $rose(rsp_valid), $past(req_valid && req_ready && (req_byte_in == fpr_pkg::CHAR_NEWLINE), 2), "result without newline")
   `FPR_ASSERT_SAME(a_code_range, clock, reset, rsp_valid, rsp_reply_code <= fpr_pkg::CODE_MAX, "reply code out of range")
   `FPR_ASSERT_NEXT(a_stall_holds, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_reply_code) && $stable(rsp_data_port) && $stable(rsp_port_overflow), "stalled result changed")

endmodule

bind ftp_passive_reply_parser fpr_checker u_fpr_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_bus.valid),
   .req_ready         (req_bus.ready),
   .req_byte_in       (req_bus.byte_in),
   .rsp_valid         (rsp_bus.valid),
   .rsp_ready         (rsp_bus.ready),
   .rsp_reply_code    (rsp_bus.reply_code),
   .rsp_data_port     (rsp_bus.data_port),
   .rsp_port_overflow (rsp_bus.port_overflow)
);
